### rtl/gssc_pkg.sv
// Shared constants and types for the gradient region shading pipeline.
// No dependencies; gssc_recip_div and gradient_sector_shade_color import this package.
`default_nettype none

package gssc_pkg;

  // Height fixed point format and reciprocal sizing
  localparam int FRAC_BITS = 16;
  localparam int QW        = FRAC_BITS + 1;
  localparam int UNIT      = 1 << FRAC_BITS;
  localparam logic [QW-1:0] UNIT_Q = QW'(UNIT);

  // Color channels
  localparam int CH_W        = 8;
  localparam int COLOR_W     = 3 * CH_W;
  localparam int LEVEL_SHIFT = 8;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;
  localparam logic [CH_W-1:0] GRAY   = 8'd128;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHTING = 1'b0,
    CFG_EXTRA    = 1'b1
  } cfg_idx_t;

  // Gradient bound adjust codes
  typedef enum logic [1:0] {
    ADJ_NONE  = 2'd0,
    ADJ_STEP1 = 2'd1,
    ADJ_STEP2 = 2'd2,
    ADJ_STEP3 = 2'd3
  } adj_t;

  // Sideband that rides along the reciprocal divider
  typedef struct packed {
    logic [QW-1:0]      dq;
    logic [COLOR_W-1:0] lo_color;
    logic [COLOR_W-1:0] up_color;
    logic [CH_W-1:0]    level;
  } side_t;

endpackage

`default_nettype wire

### rtl/gssc_query_if.sv
// Query channel: region heights, gradient codes, colors, light level and z.
// Standalone interface, no package dependency.
`default_nettype none

interface gssc_query_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] floor_height;
  logic signed [31:0] ceiling_height;
  logic               gradient_contract;
  logic [1:0]         floor_adjust;
  logic [1:0]         ceil_adjust;
  logic [23:0]        lower_color;
  logic [23:0]        upper_color;
  logic [7:0]         light_level;
  logic signed [31:0] query_z;

  modport source (
    output valid, floor_height, ceiling_height, gradient_contract, floor_adjust,
           ceil_adjust, lower_color, upper_color, light_level, query_z,
    input  ready
  );

  modport sink (
    input  valid, floor_height, ceiling_height, gradient_contract, floor_adjust,
           ceil_adjust, lower_color, upper_color, light_level, query_z,
    output ready
  );
endinterface

`default_nettype wire

### rtl/gssc_shade_if.sv
// Result channel: shaded red, green and blue.
// Standalone interface, no package dependency.
`default_nettype none

interface gssc_shade_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

### rtl/gssc_recip_div.sv
// Pipelined restoring divider: quotient = UNIT / divisor, one bit per stage.
// Depends on gssc_pkg (widths, side_t); stalls with the shared stage enable.
`default_nettype none

module gssc_recip_div import gssc_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] divisor_i,
  input  side_t         side_i,
  output logic [QW-1:0] quot_o,
  output side_t         side_o
);

  localparam logic [QW-1:0] DIVIDEND = UNIT_Q;

  logic [QW-1:0] rem_r   [QW];
  logic [QW-1:0] quot_r  [QW];
  logic [QW-1:0] dvs_r   [QW];
  side_t         side_r  [QW];
  logic [QW-1:0] rem_nxt [QW];
  logic [QW-1:0] quot_nxt[QW];

  // One trial subtract per stage; the remainder always stays below the divisor
  always_comb begin
    logic [QW-1:0] rin;
    logic [QW-1:0] qin;
    logic [QW-1:0] din;
    logic [QW:0]   sh;
    logic [QW:0]   diff;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rin = '0;
        qin = '0;
        din = divisor_i;
      end else begin
        rin = rem_r[k-1];
        qin = quot_r[k-1];
        din = dvs_r[k-1];
      end
      sh          = {rin, DIVIDEND[QW-1-k]};
      diff        = sh - {1'b0, din};
      ge          = (sh >= {1'b0, din});
      rem_nxt[k]  = ge ? diff[QW-1:0] : sh[QW-1:0];
      quot_nxt[k] = {qin[QW-2:0], ge};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        quot_r[k] <= quot_nxt[k];
      end
      dvs_r[0]  <= divisor_i;
      side_r[0] <= side_i;
      for (int k = 1; k < QW; k++) begin
        dvs_r[k]  <= dvs_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign quot_o = quot_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule

`default_nettype wire

### rtl/gradient_sector_shade_color.sv
// Channel    Dir  Handshake          Contents
// in_ch      in   valid/ready        heights, adjust codes, colors, light level, z
// out_ch     out  valid/ready        red, green, blue
// cfg_*      in   cfg_we, no ready   lighting_enable (index 0), extra_light (index 1)
//
// One query per cycle while the skid register is empty; results leave through the output register.
// The 17-stage reciprocal divider (one quotient bit per stage) sets the depth.
// A skid register behind the output keeps taking queries while a result waits;
// a stall freezes all stages together once the skid register is full.
// rst_n is synchronous: it clears the valid bits and loads the config defaults.
// Depends on gssc_pkg, gssc_query_if, gssc_shade_if and gssc_recip_div.
`default_nettype none

module gradient_sector_shade_color import gssc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  gssc_query_if.sink            in_ch,
  gssc_shade_if.source          out_ch
);

  localparam int BW  = 38;               // bound arithmetic, holds up to 5x height
  localparam int SW  = BW - FRAC_BITS;   // shaded height in whole units
  localparam int MW  = 2 * QW;           // t before clamping
  localparam int PW  = QW + CH_W;        // color times weight
  localparam int LW  = 2 * CH_W;         // level times channel
  localparam int NST = 4 + QW + 4;       // stages up to the saturated color

  localparam logic signed [SW-1:0] UNIT_S = SW'(UNIT);
  localparam logic signed [BW-1:0] UNIT_B = BW'(UNIT);

  // Configuration registers
  logic                  lighting_r;
  logic [CFG_DATA_W-1:0] extra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lighting_r <= 1'b1;
      extra_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_LIGHTING: lighting_r <= cfg_wdata[0];
        CFG_EXTRA:    extra_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Stage enable and valid bits
  logic           en;
  logic [NST-1:0] v_r;
  logic           out_v_r;
  logic           skid_v_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_ch.valid};
    end
  end

  // Stage 0: capture the query, form the region height
  logic signed [31:0]  flo0_r, cei0_r, z0_r;
  logic signed [32:0]  h0_r;
  logic                con0_r;
  adj_t                fadj0_r, cadj0_r;
  logic [COLOR_W-1:0]  lc0_r, uc0_r;
  logic [CH_W-1:0]     lvl0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      flo0_r  <= in_ch.floor_height;
      cei0_r  <= in_ch.ceiling_height;
      h0_r    <= 33'(in_ch.ceiling_height) - 33'(in_ch.floor_height);
      con0_r  <= in_ch.gradient_contract;
      fadj0_r <= adj_t'(in_ch.floor_adjust);
      cadj0_r <= adj_t'(in_ch.ceil_adjust);
      lc0_r   <= in_ch.lower_color;
      uc0_r   <= in_ch.upper_color;
      lvl0_r  <= in_ch.light_level;
      z0_r    <= in_ch.query_z;
    end
  end

  // Stage 1: shift the gradient bounds by fractions of the height
  logic signed [BW-1:0] hx, h3, lo1_nxt, up1_nxt;
  logic signed [BW-1:0] lo1_r, up1_r;
  logic signed [31:0]   z1_r;
  logic [COLOR_W-1:0]   lc1_r, uc1_r;
  logic [CH_W-1:0]      lvl1_r;

  always_comb begin
    hx      = BW'(h0_r);
    h3      = hx + (hx <<< 1);
    lo1_nxt = BW'(flo0_r);
    up1_nxt = BW'(cei0_r);
    if (con0_r) begin
      case (fadj0_r)
        ADJ_STEP1: lo1_nxt = BW'(flo0_r) + (hx >>> 2);
        ADJ_STEP2: lo1_nxt = BW'(flo0_r) + (hx >>> 1);
        ADJ_STEP3: lo1_nxt = BW'(flo0_r) + (h3 >>> 2);
        default:   lo1_nxt = BW'(flo0_r);
      endcase
      case (cadj0_r)
        ADJ_STEP1: up1_nxt = BW'(cei0_r) - (hx >>> 2);
        ADJ_STEP2: up1_nxt = BW'(cei0_r) - (hx >>> 1);
        ADJ_STEP3: up1_nxt = BW'(cei0_r) - (h3 >>> 2);
        default:   up1_nxt = BW'(cei0_r);
      endcase
    end else begin
      case (fadj0_r)
        ADJ_STEP1: lo1_nxt = BW'(flo0_r) - (hx >>> 1);
        ADJ_STEP2: lo1_nxt = BW'(flo0_r) - hx;
        ADJ_STEP3: lo1_nxt = BW'(flo0_r) - (hx <<< 1);
        default:   lo1_nxt = BW'(flo0_r);
      endcase
      case (cadj0_r)
        ADJ_STEP1: up1_nxt = BW'(cei0_r) + (hx >>> 1);
        ADJ_STEP2: up1_nxt = BW'(cei0_r) + hx;
        ADJ_STEP3: up1_nxt = BW'(cei0_r) + (hx <<< 1);
        default:   up1_nxt = BW'(cei0_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1_r  <= lo1_nxt;
      up1_r  <= up1_nxt;
      z1_r   <= z0_r;
      lc1_r  <= lc0_r;
      uc1_r  <= uc0_r;
      lvl1_r <= lvl0_r;
    end
  end

  // Stage 2: shaded height in whole units and distance above the lower bound
  logic signed [BW-1:0] span2;
  logic signed [SW-1:0] shade2_r;
  logic signed [BW-1:0] d2_r;
  logic [COLOR_W-1:0]   lc2_r, uc2_r;
  logic [CH_W-1:0]      lvl2_r;

  assign span2 = up1_r - lo1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      shade2_r <= SW'(span2 >>> FRAC_BITS);
      d2_r     <= BW'(z1_r) - lo1_r;
      lc2_r    <= lc1_r;
      uc2_r    <= uc1_r;
      lvl2_r   <= lvl1_r;
    end
  end

  // Stage 3: pick the divisor and clamp the whole-unit distance
  logic signed [BW-1:0] dsh3;
  logic [QW-1:0]        dvs3_nxt, dq3_nxt;
  logic [QW-1:0]        dvs3_r;
  side_t                side3_r;

  assign dsh3 = d2_r >>> FRAC_BITS;

  always_comb begin
    // Non-positive height divides by one; a height above 65536 whole units gives zero
    if (shade2_r <= 0) begin
      dvs3_nxt = QW'(1);
    end else if (shade2_r > UNIT_S) begin
      dvs3_nxt = UNIT_Q + QW'(1);
    end else begin
      dvs3_nxt = shade2_r[QW-1:0];
    end
    // Below the lower bound counts as zero; beyond 65536 whole units t saturates anyway
    if (d2_r[BW-1]) begin
      dq3_nxt = '0;
    end else if (dsh3 > UNIT_B) begin
      dq3_nxt = UNIT_Q;
    end else begin
      dq3_nxt = dsh3[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs3_r            <= dvs3_nxt;
      side3_r.dq        <= dq3_nxt;
      side3_r.lo_color  <= lc2_r;
      side3_r.up_color  <= uc2_r;
      side3_r.level     <= lvl2_r;
    end
  end

  // Reciprocal stages
  logic [QW-1:0] quot_d;
  side_t         side_d;

  gssc_recip_div u_recip_div (
    .clk       (clk),
    .en        (en),
    .divisor_i (dvs3_r),
    .side_i    (side3_r),
    .quot_o    (quot_d),
    .side_o    (side_d)
  );

  // Stage M: blend weight before clamping
  logic [MW-1:0] traw_r;
  side_t         side_m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      traw_r   <= side_d.dq * quot_d;
      side_m_r <= side_d;
    end
  end

  // Stage T: clamp t and weight both colors per channel
  logic [QW-1:0]          t_t, tinv_t;
  logic [2:0][PW-1:0]     plo_r, pup_r;
  logic [CH_W-1:0]        lvl_t_r;

  assign t_t    = (traw_r > MW'(UNIT)) ? UNIT_Q : traw_r[QW-1:0];
  assign tinv_t = UNIT_Q - t_t;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        plo_r[c] <= PW'(side_m_r.lo_color[c*CH_W +: CH_W]) * PW'(tinv_t);
        pup_r[c] <= PW'(side_m_r.up_color[c*CH_W +: CH_W]) * PW'(t_t);
      end
      lvl_t_r <= side_m_r.level;
    end
  end

  // Stage C: drop the fraction and scale by light level
  logic [2:0][PW-1:0] sum_c;
  logic [2:0][LW-1:0] scl_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = plo_r[c] + pup_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        scl_r[c] <= LW'(lvl_t_r) * LW'(sum_c[c][FRAC_BITS +: CH_W]);
      end
    end
  end

  // Stage S: add extra light, saturate, apply the lighting switch
  logic [2:0][CH_W:0]   bright_s;
  logic [2:0][CH_W-1:0] rgb_nxt, rgb_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bright_s[c] = {1'b0, scl_r[c][LEVEL_SHIFT +: CH_W]} + {1'b0, extra_r};
      if (!lighting_r) begin
        rgb_nxt[c] = GRAY;
      end else if (bright_s[c][CH_W]) begin
        rgb_nxt[c] = CH_MAX;
      end else begin
        rgb_nxt[c] = bright_s[c][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb_r <= rgb_nxt;
    end
  end

  // Output register with a skid register behind it
  logic [2:0][CH_W-1:0] out_rgb_r, skid_rgb_r;
  logic                 out_load;

  assign out_load = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r  <= skid_v_r || v_r[NST-1];
      skid_v_r <= 1'b0;
    end else if (en && v_r[NST-1]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rgb_r <= skid_v_r ? skid_rgb_r : rgb_r;
    end else if (en) begin
      skid_rgb_r <= rgb_r;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.red   = out_rgb_r[2];
  assign out_ch.green = out_rgb_r[1];
  assign out_ch.blue  = out_rgb_r[0];

endmodule

`default_nettype wire

### rtl/gssc_checker.sv
// Port-level checks for the gradient shading block, bound to its top level.
// Depends only on the top level's ports; no package needed.
`default_nettype none

module gssc_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] red,
  input wire [7:0] green,
  input wire [7:0] blue
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backpressure only comes from a held result
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("input stalled without a held result");

  // A result offered and not taken stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transaction");

  // Held result payload does not change
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("result payload changed while stalled");

  // Ready is known whenever a query is offered
  a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_ready))
    else $error("input ready unknown");

endmodule

bind gradient_sector_shade_color gssc_checker u_gssc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue)
);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for gradient_sector_shade_color: directed table, then random queries.
// Each result is checked against a built-in shading predictor.
// Depends on gssc_pkg, gssc_query_if, gssc_shade_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import gssc_pkg::*;

  typedef struct packed {
    bit signed [31:0] floor_h;
    bit signed [31:0] ceil_h;
    bit               contract;
    adj_t             floor_adj;
    adj_t             ceil_adj;
    bit [23:0]        lower_color;
    bit [23:0]        upper_color;
    bit [7:0]         level;
    bit signed [31:0] z;
  } query_t;

  typedef struct packed {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } shade_t;

  typedef struct {
    query_t   q;
    bit       lit;
    bit [7:0] extra;
    bit       fixed;
    bit [7:0] want;
  } dir_row_t;

  localparam bit KNOWN   = 1'b1;
  localparam bit CALC    = 1'b0;
  localparam bit LIT_ON  = 1'b1;
  localparam bit LIT_OFF = 1'b0;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_SETTING = 160;

  bit clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gssc_query_if q_if ();
  gssc_shade_if s_if ();

  gradient_sector_shade_color u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (q_if),
    .out_ch    (s_if)
  );

  // Predictor copy of the configuration registers
  bit       lit_en = 1'b1;
  bit [7:0] extra_lvl = 8'd0;

  shade_t      pending_shades[$];
  int          error_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_used;
  int          hold_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Blend one channel by t, scale by light level, add extra light, saturate
  function automatic bit [7:0] blend_ch(bit [7:0] lo, bit [7:0] up, longint t, bit [7:0] lv);
    longint c;
    longint v;
    c = (longint'(lo) * (UNIT - t) + longint'(up) * t) >>> FRAC_BITS;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    v = ((longint'(lv) * c) >>> LEVEL_SHIFT) + longint'(extra_lvl);
    return (v > 255) ? CH_MAX : v[7:0];
  endfunction

  // Work out the shaded color of one query under the current configuration
  function automatic shade_t shade_query(query_t q);
    longint flo, cei, h, lower, upper, span, recip, d, t;
    shade_t s;
    if (!lit_en) begin
      s.red = GRAY;
      s.green = GRAY;
      s.blue = GRAY;
      return s;
    end
    flo = $signed(q.floor_h);
    cei = $signed(q.ceil_h);
    h = cei - flo;
    lower = flo;
    upper = cei;
    if (q.contract) begin
      case (q.floor_adj)
        ADJ_STEP1: lower += h >>> 2;
        ADJ_STEP2: lower += h >>> 1;
        ADJ_STEP3: lower += (h * 3) >>> 2;
        default: ;
      endcase
      case (q.ceil_adj)
        ADJ_STEP1: upper -= h >>> 2;
        ADJ_STEP2: upper -= h >>> 1;
        ADJ_STEP3: upper -= (h * 3) >>> 2;
        default: ;
      endcase
    end else begin
      case (q.floor_adj)
        ADJ_STEP1: lower -= h >>> 1;
        ADJ_STEP2: lower -= h;
        ADJ_STEP3: lower -= h * 2;
        default: ;
      endcase
      case (q.ceil_adj)
        ADJ_STEP1: upper += h >>> 1;
        ADJ_STEP2: upper += h;
        ADJ_STEP3: upper += h * 2;
        default: ;
      endcase
    end
    span = (upper - lower) >>> FRAC_BITS;
    recip = (span > 0) ? longint'(UNIT) / span : longint'(UNIT);
    d = $signed(q.z) - lower;
    if (d < 0) d = 0;
    t = (d >>> FRAC_BITS) * recip;
    if (t > UNIT) t = UNIT;
    s.red   = blend_ch(q.lower_color[23:16], q.upper_color[23:16], t, q.level);
    s.green = blend_ch(q.lower_color[15:8], q.upper_color[15:8], t, q.level);
    s.blue  = blend_ch(q.lower_color[7:0], q.upper_color[7:0], t, q.level);
    return s;
  endfunction

  function automatic dir_row_t mk_row(bit [31:0] fl, bit [31:0] ce, bit con, adj_t fa,
      adj_t ca, bit [23:0] lc, bit [23:0] uc, bit [7:0] lv, bit [31:0] z, bit lit,
      bit [7:0] ex, bit fixed, bit [7:0] want);
    dir_row_t r;
    r.q.floor_h = fl;
    r.q.ceil_h = ce;
    r.q.contract = con;
    r.q.floor_adj = fa;
    r.q.ceil_adj = ca;
    r.q.lower_color = lc;
    r.q.upper_color = uc;
    r.q.level = lv;
    r.q.z = z;
    r.lit = lit;
    r.extra = ex;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  // Mostly well-formed regions with z near the gradient; some fully random fields
  function automatic query_t rand_query();
    query_t q;
    int base, span, lim, zoff;
    q.contract = 1'($urandom_range(1));
    q.floor_adj = adj_t'(2'($urandom_range(3)));
    q.ceil_adj = adj_t'(2'($urandom_range(3)));
    q.lower_color = 24'($urandom);
    q.upper_color = 24'($urandom);
    q.level = 8'($urandom);
    if ($urandom_range(7) == 0) begin
      q.floor_h = $urandom;
      q.ceil_h = $urandom;
      q.z = $urandom;
    end else begin
      base = int'($urandom_range(2000)) - 1000;
      span = ($urandom_range(9) == 0) ? -int'($urandom_range(8)) : int'($urandom_range(1, 300));
      lim = (span > 0) ? span : 8;
      zoff = int'($urandom_range(4 * lim)) - 2 * lim;
      q.floor_h = (base <<< 16) + int'($urandom_range(16'hffff));
      q.ceil_h = q.floor_h + (span <<< 16) + int'($urandom_range(16'hffff));
      q.z = q.floor_h + (zoff <<< 16) + int'($urandom_range(16'hffff));
    end
    return q;
  endfunction

  // Drain, then write both registers while the block is idle
  task automatic apply_config(bit lit, bit [7:0] extra);
    q_if.valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_LIGHTING;
    cfg_wdata <= CFG_DATA_W'(lit);
    @(posedge clk);
    cfg_idx <= CFG_EXTRA;
    cfg_wdata <= extra;
    @(posedge clk);
    cfg_we <= 1'b0;
    lit_en = lit;
    extra_lvl = extra;
    @(posedge clk);
  endtask

  // Offer one query after a random gap; record its expected shade on acceptance
  task automatic send_query(query_t q, bit fixed, bit [7:0] want);
    shade_t exp_shade;
    while ($urandom_range(99) < tx_idle_pct) begin
      q_if.valid <= 1'b0;
      @(posedge clk);
    end
    q_if.valid <= 1'b1;
    q_if.floor_height <= q.floor_h;
    q_if.ceiling_height <= q.ceil_h;
    q_if.gradient_contract <= q.contract;
    q_if.floor_adjust <= q.floor_adj;
    q_if.ceil_adjust <= q.ceil_adj;
    q_if.lower_color <= q.lower_color;
    q_if.upper_color <= q.upper_color;
    q_if.light_level <= q.level;
    q_if.query_z <= q.z;
    do @(posedge clk); while (!q_if.ready);
    if (fixed) begin
      exp_shade.red = want;
      exp_shade.green = want;
      exp_shade.blue = want;
    end else begin
      exp_shade = shade_query(q);
    end
    pending_shades.push_back(exp_shade);
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      s_if.ready <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      s_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      s_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      s_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_ch(string name, bit [7:0] got, bit [7:0] want);
    if (got !== want) report_error($sformatf("%s mismatch: got %0d, want %0d", name, got, want));
  endtask

  // Compare each accepted result against the oldest expected shade
  always @(posedge clk) begin
    shade_t want;
    if (rst_n === 1'b1 && s_if.valid === 1'b1 && s_if.ready === 1'b1) begin
      if (pending_shades.size() == 0) begin
        report_error($sformatf("unexpected result %0d,%0d,%0d",
                               s_if.red, s_if.green, s_if.blue));
      end else begin
        want = pending_shades.pop_front();
        check_ch("red", s_if.red, want.red);
        check_ch("green", s_if.green, want.green);
        check_ch("blue", s_if.blue, want.blue);
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t dir_tab[$];
    int unsigned tx_pct_tab[3];
    int unsigned rx_pct_tab[3];
    bit [7:0] extra_tab[4];
    bit lit_tab[4];
    tx_pct_tab = '{38, 50, 0};
    rx_pct_tab = '{50, 38, 0};

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_LIGHTING;
    cfg_wdata = '0;
    q_if.valid = 1'b0;
    q_if.floor_height = '0;
    q_if.ceiling_height = '0;
    q_if.gradient_contract = 1'b0;
    q_if.floor_adjust = ADJ_NONE;
    q_if.ceil_adjust = ADJ_NONE;
    q_if.lower_color = '0;
    q_if.upper_color = '0;
    q_if.light_level = '0;
    q_if.query_z = '0;
    s_if.ready = 1'b0;

    // Directed rows: reset config, extremes, every adjust code, special regions
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b0, ADJ_NONE, ADJ_NONE,
        24'h000000, 24'h000000, 8'd255, 32'h0008_0000, LIT_ON, 8'd0, KNOWN, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b0, ADJ_NONE, ADJ_NONE,
        24'hffffff, 24'hffffff, 8'd255, 32'h8000_0000, LIT_ON, 8'd0, KNOWN, 8'd254));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b1, ADJ_STEP2, ADJ_STEP1,
        24'hffffff, 24'hffffff, 8'd0, 32'h7fff_ffff, LIT_ON, 8'd0, KNOWN, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b0, ADJ_NONE, ADJ_NONE,
        24'h000000, 24'hffffff, 8'd255, 32'h0008_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b1, ADJ_STEP1, ADJ_STEP1,
        24'h102030, 24'hf0e0d0, 8'd255, 32'h0006_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b1, ADJ_STEP2, ADJ_STEP2,
        24'h102030, 24'hf0e0d0, 8'd200, 32'h0009_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b1, ADJ_STEP3, ADJ_STEP3,
        24'h804020, 24'h2040ff, 8'd255, 32'h000c_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0007_0003, 1'b1, ADJ_STEP3, ADJ_NONE,
        24'h000000, 24'hffffff, 8'd255, 32'h0006_8000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b0, ADJ_STEP1, ADJ_STEP1,
        24'h00ff00, 24'hff00ff, 8'd255, 32'h000a_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0001_0000, 32'h0005_0000, 1'b0, ADJ_STEP2, ADJ_STEP3,
        24'h00ff00, 24'hff00ff, 8'd255, 32'h0004_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0001_0000, 32'h0005_0000, 1'b0, ADJ_STEP3, ADJ_STEP2,
        24'h123456, 24'hfedcba, 8'd255, 32'hfffe_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0010_0000, 32'h0000_0000, 1'b0, ADJ_NONE, ADJ_NONE,
        24'h000000, 24'hffffff, 8'd255, 32'h0010_8000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0005_0000, 32'h0005_0000, 1'b1, ADJ_NONE, ADJ_NONE,
        24'h000000, 24'hffffff, 8'd255, 32'h0005_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0010_0000, 32'h0020_0000, 1'b0, ADJ_NONE, ADJ_NONE,
        24'h123456, 24'habcdef, 8'd200, 32'hfff0_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h8000_0000, 32'h7fff_ffff, 1'b0, ADJ_STEP3, ADJ_STEP3,
        24'h55aa55, 24'haa55aa, 8'd255, 32'h7fff_ffff, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h7fff_ffff, 32'h8000_0000, 1'b1, ADJ_STEP3, ADJ_STEP3,
        24'hffffff, 24'h000000, 8'd255, 32'h8000_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'hfff0_0000, 32'hfff8_0000, 1'b1, ADJ_STEP1, ADJ_STEP3,
        24'h00ff00, 24'hff00ff, 8'd128, 32'hfff4_0000, LIT_ON, 8'd0, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b0, ADJ_NONE, ADJ_NONE,
        24'h000000, 24'h000000, 8'd0, 32'h0000_0000, LIT_ON, 8'd255, KNOWN, 8'd255));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b1, ADJ_STEP3, ADJ_STEP1,
        24'hffffff, 24'h00ff00, 8'd255, 32'h0008_0000, LIT_ON, 8'd255, KNOWN, 8'd255));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0010_0000, 1'b0, ADJ_STEP1, ADJ_STEP2,
        24'h204060, 24'hc0a080, 8'd180, 32'h0008_0000, LIT_ON, 8'd100, CALC, 8'd0));
    dir_tab.push_back(mk_row(32'h7fff_ffff, 32'h7fff_ffff, 1'b1, ADJ_STEP3, ADJ_STEP3,
        24'hffffff, 24'hffffff, 8'd255, 32'h7fff_ffff, LIT_OFF, 8'd0, KNOWN, 8'd128));
    dir_tab.push_back(mk_row(32'h0000_0000, 32'h0000_0000, 1'b0, ADJ_NONE, ADJ_NONE,
        24'h000000, 24'h000000, 8'd0, 32'h0000_0000, LIT_OFF, 8'd0, KNOWN, 8'd128));
    dir_tab.push_back(mk_row(32'h8000_0000, 32'h0010_0000, 1'b0, ADJ_STEP2, ADJ_STEP1,
        24'h000000, 24'hffffff, 8'd255, 32'h8000_0000, LIT_OFF, 8'd255, KNOWN, 8'd128));

    tx_idle_pct = tx_pct_tab[0];
    rx_idle_pct = rx_pct_tab[0];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table, rewriting the registers when a row asks for new values
    foreach (dir_tab[i]) begin
      if (dir_tab[i].lit != lit_en || dir_tab[i].extra != extra_lvl)
        apply_config(dir_tab[i].lit, dir_tab[i].extra);
      send_query(dir_tab[i].q, dir_tab[i].fixed, dir_tab[i].want);
    end

    // Random queries: three idling patterns, each under four register settings
    for (int mode = 0; mode < 3; mode++) begin
      lit_tab = '{LIT_ON, LIT_ON, LIT_OFF, LIT_ON};
      extra_tab = '{8'd0, 8'd255, 8'($urandom_range(255)), 8'($urandom_range(1, 254))};
      for (int s = 0; s < 4; s++) begin
        apply_config(lit_tab[s], extra_tab[s]);
        tx_idle_pct = tx_pct_tab[mode];
        rx_idle_pct = rx_pct_tab[mode];
        if (mode == 2 && s == 0) hold_req = 1'b1;
        repeat (ITEMS_PER_SETTING) send_query(rand_query(), CALC, 8'd0);
      end
    end

    // Drain and let the pipeline settle
    q_if.valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/gssc_pkg.sv
rtl/gssc_query_if.sv
rtl/gssc_shade_if.sv
rtl/gssc_recip_div.sv
rtl/gradient_sector_shade_color.sv
rtl/gssc_checker.sv
test/testbench.sv
